// ===== src/km2d_pkg.sv =====
// ----------------------------------------------------------------------------
// km2d_pkg
// Shared types, constants and command codes for the 2D k-means block.
// ----------------------------------------------------------------------------
package km2d_pkg;

	localparam int MAX_CLUSTERS = 4;
	localparam int CL_BITS      = 2;
	localparam int COORD_BITS   = 16;
	localparam int SUM_BITS     = 40;
	localparam int CNT_BITS     = 25;
	localparam int DIST_BITS    = 2 * COORD_BITS + 1;
	localparam int QUO_BITS     = SUM_BITS + 1;
	localparam logic [CNT_BITS-1:0] MAX_POINTS = CNT_BITS'(24'hFFFFFF) + CNT_BITS'(1);

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_POINT  = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_PICK,
		ST_UPD,
		ST_DIV,
		ST_REPORT,
		ST_CLEAR,
		ST_START
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_center;
		logic capture;
		logic square;
		logic pick;
		logic update;
		logic div_start;
		logic div_step;
		logic report;
		logic clear;
		logic [CL_BITS-1:0] idx;
	} ctrl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic div_done;
		logic [2:0] active;
	} stat_t;

endpackage

// ===== src/km2d_datapath.sv =====
// ----------------------------------------------------------------------------
// km2d_datapath
// Center and accumulator registers, distance unit, shared serial divider.
// ----------------------------------------------------------------------------
module km2d_datapath import km2d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	output stat_t                 stat,
	input  logic [2:0]            cfg_q,
	input  logic [CL_BITS-1:0]    in_slot,
	input  logic [COORD_BITS-1:0] in_x,
	input  logic [COORD_BITS-1:0] in_y,
	input  logic [CL_BITS-1:0]    in_prior,
	input  logic                  in_pvalid,
	output logic [CL_BITS-1:0]    res_cluster,
	output logic [COORD_BITS-1:0] res_cx,
	output logic [COORD_BITS-1:0] res_cy,
	output logic [CNT_BITS-1:0]   res_cnt,
	output logic                  res_changed
);

	logic [COORD_BITS-1:0] cx_q [MAX_CLUSTERS];
	logic [COORD_BITS-1:0] cy_q [MAX_CLUSTERS];
	logic [SUM_BITS-1:0]   sx_q [MAX_CLUSTERS];
	logic [SUM_BITS-1:0]   sy_q [MAX_CLUSTERS];
	logic [CNT_BITS-1:0]   cnt_q [MAX_CLUSTERS];
	logic                  anych_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [CL_BITS-1:0]    prior_q;
	logic                  pvalid_q;
	logic [DIST_BITS-1:0]  d_q [MAX_CLUSTERS];
	logic [CL_BITS-1:0]    best_q;
	logic                  chg_q;
	// divider: x and y in parallel
	logic [SUM_BITS:0]     nx_q, ny_q;
	logic [CNT_BITS:0]     rx_q, ry_q;
	logic [QUO_BITS-1:0]   qx_q, qy_q;
	logic [5:0]            dcnt_q;
	logic [2:0]            active;

	assign active = (cfg_q == 3'd0) ? 3'd1 : (cfg_q > 3'd4) ? 3'd4 : cfg_q;
	assign stat.active = active;
	assign stat.div_done = (dcnt_q == 6'd0);

	// Absolute differences per cluster; squares are registered on ctrl.square
	logic [COORD_BITS-1:0] dx [MAX_CLUSTERS];
	logic [COORD_BITS-1:0] dy [MAX_CLUSTERS];
	always_comb begin
		for (int j = 0; j < MAX_CLUSTERS; j++) begin
			dx[j] = (cx_q[j] >= px_q) ? cx_q[j] - px_q : px_q - cx_q[j];
			dy[j] = (cy_q[j] >= py_q) ? cy_q[j] - py_q : py_q - cy_q[j];
		end
	end

	// Nearest center, ties to lower index
	logic [CL_BITS-1:0] best;
	always_comb begin
		logic [DIST_BITS-1:0] bd;
		best = '0;
		bd = d_q[0];
		for (int j = 1; j < MAX_CLUSTERS; j++) begin
			if (j < int'(active) && d_q[j] < bd) begin
				best = CL_BITS'(j);
				bd = d_q[j];
			end
		end
	end

	logic [CL_BITS-1:0] idx;
	logic [CNT_BITS-1:0] c_sel;
	logic [SUM_BITS:0] nx0, ny0;
	logic [CNT_BITS:0] trx, try_;
	assign idx = ctrl.idx;
	assign c_sel = cnt_q[idx];
	assign nx0 = {1'b0, sx_q[idx]} + (SUM_BITS+1)'(c_sel >> 1);
	assign ny0 = {1'b0, sy_q[idx]} + (SUM_BITS+1)'(c_sel >> 1);
	assign trx = {rx_q[CNT_BITS-1:0], nx_q[SUM_BITS]};
	assign try_ = {ry_q[CNT_BITS-1:0], ny_q[SUM_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_CLUSTERS; j++) begin
				cx_q[j] <= '0; cy_q[j] <= '0;
				sx_q[j] <= '0; sy_q[j] <= '0; cnt_q[j] <= '0;
			end
			anych_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (ctrl.load_center) begin
				cx_q[in_slot] <= in_x;
				cy_q[in_slot] <= in_y;
			end
			if (ctrl.update) begin
				if (cnt_q[best_q] < MAX_POINTS) begin
					cnt_q[best_q] <= cnt_q[best_q] + CNT_BITS'(1);
					sx_q[best_q] <= sx_q[best_q] + SUM_BITS'(px_q);
					sy_q[best_q] <= sy_q[best_q] + SUM_BITS'(py_q);
				end
				anych_q <= anych_q | chg_q;
			end
			// Restoring divide, one quotient bit per cycle
			if (ctrl.div_start) begin
				dcnt_q <= 6'(SUM_BITS + 1);
			end else if (ctrl.div_step && dcnt_q != 6'd0) begin
				dcnt_q <= dcnt_q - 6'd1;
			end
			// Write new center when the cluster was non-empty
			if (ctrl.report && c_sel != '0) begin
				cx_q[idx] <= qx_q[COORD_BITS-1:0];
				cy_q[idx] <= qy_q[COORD_BITS-1:0];
			end
			if (ctrl.clear) begin
				for (int j = 0; j < MAX_CLUSTERS; j++) begin
					sx_q[j] <= '0; sy_q[j] <= '0; cnt_q[j] <= '0;
				end
				anych_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			px_q <= in_x; py_q <= in_y;
			prior_q <= in_prior; pvalid_q <= in_pvalid;
		end
		if (ctrl.square) begin
			for (int j = 0; j < MAX_CLUSTERS; j++) begin
				d_q[j] <= DIST_BITS'(dx[j] * dx[j]) + DIST_BITS'(dy[j] * dy[j]);
			end
		end
		if (ctrl.pick) begin
			best_q <= best;
			chg_q <= !pvalid_q || (prior_q != best);
		end
		if (ctrl.div_start) begin
			nx_q <= nx0; ny_q <= ny0;
			rx_q <= '0; ry_q <= '0;
			qx_q <= '0; qy_q <= '0;
		end else if (ctrl.div_step && dcnt_q != 6'd0) begin
			nx_q <= {nx_q[SUM_BITS-1:0], 1'b0};
			ny_q <= {ny_q[SUM_BITS-1:0], 1'b0};
			if (trx >= {1'b0, c_sel}) begin
				rx_q <= trx - {1'b0, c_sel};
				qx_q <= {qx_q[QUO_BITS-2:0], 1'b1};
			end else begin
				rx_q <= trx;
				qx_q <= {qx_q[QUO_BITS-2:0], 1'b0};
			end
			if (try_ >= {1'b0, c_sel}) begin
				ry_q <= try_ - {1'b0, c_sel};
				qy_q <= {qy_q[QUO_BITS-2:0], 1'b1};
			end else begin
				ry_q <= try_;
				qy_q <= {qy_q[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	// Result fields for the output register
	always_comb begin
		if (ctrl.report) begin
			res_cluster = idx;
			res_cx = (c_sel != '0) ? qx_q[COORD_BITS-1:0] : cx_q[idx];
			res_cy = (c_sel != '0) ? qy_q[COORD_BITS-1:0] : cy_q[idx];
			res_cnt = c_sel;
			res_changed = anych_q;
		end else begin
			res_cluster = best_q;
			res_cx = '0;
			res_cy = '0;
			res_cnt = '0;
			res_changed = chg_q;
		end
	end

endmodule

// ===== src/km2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// km2d_ctrl
// Sequencer for load, point and end-of-pass commands.
// ----------------------------------------------------------------------------
module km2d_ctrl import km2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [1:0]         in_cmd,
	input  logic               out_free,
	input  stat_t              stat,
	output ctrl_t              ctrl,
	output logic               busy,
	output logic               out_load,
	output logic               out_kind,
	output logic               out_last
);

	state_t state_q, state_d;
	logic [CL_BITS-1:0] idx_q, idx_d;

	// Next state
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_cmd == CMD_POINT) state_d = ST_DIST;
				else if (in_fire && in_cmd == CMD_END) begin
					state_d = ST_DIV;
					idx_d = '0;
				end
			end
			ST_DIST: state_d = ST_PICK;
			ST_PICK: state_d = ST_UPD;
			ST_UPD:  if (out_free) state_d = ST_IDLE;
			ST_DIV:  if (stat.div_done) state_d = ST_REPORT;
			ST_REPORT: begin
				if (out_free) begin
					if (3'(idx_q) + 3'd1 == stat.active) state_d = ST_CLEAR;
					else begin
						idx_d = idx_q + CL_BITS'(1);
						state_d = ST_START;
					end
				end
			end
			ST_START: state_d = ST_DIV;
			ST_CLEAR: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		ctrl.idx = idx_q;
		out_load = 1'b0;
		out_kind = 1'b0;
		out_last = 1'b0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ctrl.capture = in_fire;
				ctrl.load_center = in_fire && in_cmd == CMD_LOAD;
				ctrl.div_start = in_fire && in_cmd == CMD_END;
				ctrl.idx = '0;
			end
			ST_DIST: ctrl.square = 1'b1;
			ST_PICK: ctrl.pick = 1'b1;
			ST_UPD: begin
				ctrl.update = out_free;
				out_load = out_free;
			end
			ST_DIV: ctrl.div_step = 1'b1;
			ST_REPORT: begin
				ctrl.report = out_free;
				out_load = out_free;
				out_kind = 1'b1;
				out_last = (3'(idx_q) + 3'd1 == stat.active);
				ctrl.idx = idx_q;
			end
			// Load the divider for the following index
			ST_START: ctrl.div_start = 1'b1;
			ST_CLEAR: ctrl.clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

endmodule

// ===== src/kmeans_2d_assign_update.sv =====
// ----------------------------------------------------------------------------
// kmeans_2d_assign_update
// One pass of 2D k-means: load centers, label points, report new centers.
// ----------------------------------------------------------------------------
// channel     | direction | contents
// s_axis      | in        | command, slot, point, prior label
// m_axis      | out       | label results and center reports
// cfg         | in        | clusters_in_use
// Load: writes the center slot on acceptance. Point: capture, squares, pick, accumulate.
// End: per cluster a divider start (the accept cycle for the first), the
// shared bit-serial divider and a report, then a clear.
// Reset clears centers, sums, counts; clusters_in_use resets to 4.
// A stalled output register holds the sequencer in place.
module kmeans_2d_assign_update import km2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[1:0], center_slot[3:2], coord_x[19:4], coord_y[35:20],
	// prior_label[37:36], prior_valid[38], zeros above
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// cluster[1:0], center_x[17:2], center_y[33:18], member_count[58:34],
	// changed[59], zeros above
	output logic [63:0] m_axis_tdata,
	// kind[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);

	logic [2:0] cfg_q;
	ctrl_t ctrl;
	stat_t stat;
	logic busy, out_load, out_kind, out_last, in_fire, out_free;
	logic [CL_BITS-1:0] r_cl;
	logic [COORD_BITS-1:0] r_cx, r_cy;
	logic [CNT_BITS-1:0] r_cnt;
	logic r_chg;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cfg_q <= 3'd4;
		else if (cfg_we) cfg_q <= cfg_wdata;
	end

	km2d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_cmd(s_axis_tdata[1:0]),
		.out_free(out_free), .stat(stat), .ctrl(ctrl), .busy(busy),
		.out_load(out_load), .out_kind(out_kind), .out_last(out_last)
	);

	km2d_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat), .cfg_q(cfg_q),
		.in_slot(s_axis_tdata[3:2]),
		.in_x(s_axis_tdata[19:4]), .in_y(s_axis_tdata[35:20]),
		.in_prior(s_axis_tdata[37:36]), .in_pvalid(s_axis_tdata[38]),
		.res_cluster(r_cl), .res_cx(r_cx), .res_cy(r_cy), .res_cnt(r_cnt),
		.res_changed(r_chg)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {4'd0, r_chg, r_cnt, r_cy, r_cx, r_cl};
			m_axis_tuser <= out_kind;
			m_axis_tlast <= out_last;
		end
	end

	logic unused_in;
	assign unused_in = s_axis_tdata[39];

endmodule
